// ===== sv/dpn_pkg.sv =====
// Package for the drinking philosopher node: codes, state encodings and the
// structs passed between the sequencer, the slot rule unit and the result picker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpn_pkg;

  // Fixed field widths of the channels
  localparam int MAX_SLOTS  = 8;
  localparam int SLOT_W     = 3;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_PRESENT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_WITH_BOTTLE = 8'd1;

  typedef enum logic [1:0] {
    PH_TRANQUIL = 2'd0,
    PH_THIRSTY  = 2'd1,
    PH_DRINKING = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_REQ    = 2'd1,
    KIND_BOTTLE = 2'd2,
    KIND_DRINK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_BOTTLE  = 2'd1,
    MODE_REQUEST = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RULE = 2'd1,
    ST_GIVE = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  // Per-slot flags
  typedef struct packed {
    logic bottle;
    logic request;
    logic need;
    logic dirty;
  } slot_flags_t;

  // Result of evaluating one slot
  typedef struct packed {
    slot_flags_t flags;
    logic        send_req;
    logic        give_bottle;
    logic        not_ready;
  } slot_rule_t;

  // Next result chosen from the pending masks
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] target;
    logic              last;
  } pick_t;

endpackage

`default_nettype wire

// ===== sv/dpn_if.sv =====
// Valid/ready channel interfaces of the drinking philosopher node:
// input request channel, result channel and configuration write channel.
// Depends on dpn_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dpn_in_if;
  import dpn_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [SLOT_W-1:0] slot;
  logic             arrives_dirty;

  modport source (output valid, mode, slot, arrives_dirty, input ready);
  modport sink   (input valid, mode, slot, arrives_dirty, output ready);
endinterface

interface dpn_out_if;
  import dpn_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [SLOT_W-1:0] target_slot;
  logic [1:0]        phase_now;
  logic [MASK_W-1:0] bottles_held;
  logic [MASK_W-1:0] requests_held;
  logic              last;

  modport source (output valid, kind, target_slot, phase_now, bottles_held,
                  requests_held, last, input ready);
  modport sink   (input valid, kind, target_slot, phase_now, bottles_held,
                  requests_held, last, output ready);
endinterface

interface dpn_cfg_if;
  import dpn_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/dpn_slot_rule.sv =====
// Shared per-slot rule unit: evaluates the phase rule or the bottle-giving
// rule for the one slot the sequencer points at. Depends on dpn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpn_slot_rule (
  input  logic                give,
  input  dpn_pkg::phase_t     phase,
  input  logic                present,
  input  dpn_pkg::slot_flags_t flags_in,
  output dpn_pkg::slot_rule_t res
);
  import dpn_pkg::*;

  logic keep;

  always_comb begin
    res.flags       = flags_in;
    res.send_req    = 1'b0;
    res.give_bottle = 1'b0;
    res.not_ready   = 1'b0;
    // a needed bottle is kept while drinking, or while it is still clean
    keep = flags_in.need && (phase == PH_DRINKING || !flags_in.dirty);

    if (present) begin
      if (give) begin
        // hand a bottle over when the neighbor asked and we do not keep it
        if (flags_in.request && flags_in.bottle && !keep) begin
          res.give_bottle  = 1'b1;
          res.flags.bottle = 1'b0;
          res.flags.dirty  = 1'b0;
        end
      end else begin
        case (phase)
          PH_THIRSTY: begin
            if (flags_in.need && flags_in.request && !flags_in.bottle) begin
              res.send_req      = 1'b1;
              res.flags.request = 1'b0;
            end
            res.not_ready = flags_in.need && !flags_in.bottle;
          end
          PH_DRINKING: begin
            res.flags.need  = 1'b0;
            res.flags.dirty = 1'b1;
          end
          default: begin
            // tranquil (and the unused code): want every present bottle
            res.flags.need = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/dpn_result_pick.sv =====
// Result picker: takes the lowest pending request send, then the drink
// report, then the lowest pending bottle send. Depends on dpn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpn_result_pick #(
  parameter int ACTIVE = 8
) (
  input  logic [ACTIVE-1:0] req_mask,
  input  logic              drink,
  input  logic [ACTIVE-1:0] bottle_mask,
  output logic [ACTIVE-1:0] req_left,
  output logic              drink_left,
  output logic [ACTIVE-1:0] bottle_left,
  output dpn_pkg::pick_t    pick
);
  import dpn_pkg::*;

  logic [SLOT_W-1:0] req_idx;
  logic [SLOT_W-1:0] bottle_idx;

  // lowest set bit of each mask
  always_comb begin
    req_idx    = '0;
    bottle_idx = '0;
    for (int i = ACTIVE - 1; i >= 0; i--) begin
      if (req_mask[i]) req_idx = SLOT_W'(i);
      if (bottle_mask[i]) bottle_idx = SLOT_W'(i);
    end
  end

  // select by priority and drop the chosen entry
  always_comb begin
    req_left    = req_mask;
    drink_left  = drink;
    bottle_left = bottle_mask;
    pick.kind   = KIND_NONE;
    pick.target = '0;
    if (|req_mask) begin
      pick.kind   = KIND_REQ;
      pick.target = req_idx;
      req_left    = req_mask & (req_mask - ACTIVE'(1));
    end else if (drink) begin
      pick.kind  = KIND_DRINK;
      drink_left = 1'b0;
    end else if (|bottle_mask) begin
      pick.kind   = KIND_BOTTLE;
      pick.target = bottle_idx;
      bottle_left = bottle_mask & (bottle_mask - ACTIVE'(1));
    end
    pick.last = !(|req_left) && !drink_left && !(|bottle_left);
  end

endmodule

`default_nettype wire

// ===== sv/drinking_philosopher_node.sv =====
// One node of the drinking philosophers protocol: sequencer, per-slot flags
// and output register. Depends on dpn_pkg, dpn_if, dpn_slot_rule, dpn_result_pick.
//
// Usage:
//   in_if  : requests (tick, bottle arrival, request arrival) on valid/ready.
//   out_if : results on valid/ready; every request yields one or more results,
//            the final one flagged by last. A request that sends nothing gives
//            one result of kind none.
//   cfg_if : register writes (0 neighbor_present, 1 start_with_bottle), always
//            ready; write only while the node is idle. Writing
//            start_with_bottle reloads all slot flags.
// Sequence: a tick walks the slots twice through the shared slot rule unit (phase
//   rule, then bottle-giving rule), one slot per cycle, then sends one result
//   per cycle while the receiver takes them. A bottle or request arrival skips
//   the walk and goes straight to sending its result.
// in_if.ready is high only while the sequencer is idle; it does not wait for
//   the last result to be taken, which sits in the output register.
// A stalled receiver holds the output register and the sequencer in its send
//   state. Reset: tranquil, all slots present, each slot holding its request token and no bottle.
`timescale 1ns / 1ps
`default_nettype none

module drinking_philosopher_node #(
  parameter int SLOTS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  dpn_in_if.sink         in_if,
  dpn_out_if.source      out_if,
  dpn_cfg_if.sink        cfg_if
);
  import dpn_pkg::*;

  localparam int ACTIVE = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
  localparam int CW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [MASK_W-1:0] present_r, present_nxt;
  logic [ACTIVE-1:0] bottle_r, bottle_nxt;
  logic [ACTIVE-1:0] req_r, req_nxt;
  logic [ACTIVE-1:0] need_r, need_nxt;
  logic [ACTIVE-1:0] dirty_r, dirty_nxt;
  logic [ACTIVE-1:0] req_mask_r, req_mask_nxt;
  logic [ACTIVE-1:0] bottle_mask_r, bottle_mask_nxt;
  logic              drink_r, drink_nxt;
  logic              not_ready_r, not_ready_nxt;
  logic              out_valid_r, out_valid_nxt;

  // output payload registers
  kind_t             out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0] out_target_r, out_target_nxt;
  logic [1:0]        out_phase_r, out_phase_nxt;
  logic [MASK_W-1:0] out_bottles_r, out_bottles_nxt;
  logic [MASK_W-1:0] out_reqs_r, out_reqs_nxt;
  logic              out_last_r, out_last_nxt;

  slot_flags_t       cur_flags;
  slot_rule_t        rule_res;
  pick_t             pick;
  logic [ACTIVE-1:0] req_left, bottle_left;
  logic              drink_left;
  logic              msg_ok;
  logic [CW-1:0]     msg_idx;
  logic              slot_end;
  logic              load_out;

  // flags of the slot under the counter
  assign cur_flags.bottle  = bottle_r[cnt_r];
  assign cur_flags.request = req_r[cnt_r];
  assign cur_flags.need    = need_r[cnt_r];
  assign cur_flags.dirty   = dirty_r[cnt_r];
  assign slot_end          = (cnt_r == CW'(ACTIVE - 1));

  dpn_slot_rule u_rule (
    .give     (state_r == ST_GIVE),
    .phase    (phase_r),
    .present  (present_r[cnt_r]),
    .flags_in (cur_flags),
    .res      (rule_res)
  );

  dpn_result_pick #(.ACTIVE(ACTIVE)) u_pick (
    .req_mask    (req_mask_r),
    .drink       (drink_r),
    .bottle_mask (bottle_mask_r),
    .req_left    (req_left),
    .drink_left  (drink_left),
    .bottle_left (bottle_left),
    .pick        (pick)
  );

  // arriving message slot check
  assign msg_ok  = (32'(in_if.slot) < ACTIVE) && present_r[in_if.slot];
  assign msg_idx = in_if.slot[CW-1:0];

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign load_out     = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);

  // next state and datapath
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    cnt_nxt         = cnt_r;
    present_nxt     = present_r;
    bottle_nxt      = bottle_r;
    req_nxt         = req_r;
    need_nxt        = need_r;
    dirty_nxt       = dirty_r;
    req_mask_nxt    = req_mask_r;
    bottle_mask_nxt = bottle_mask_r;
    drink_nxt       = drink_r;
    not_ready_nxt   = not_ready_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_kind_nxt    = out_kind_r;
    out_target_nxt  = out_target_r;
    out_phase_nxt   = out_phase_r;
    out_bottles_nxt = out_bottles_r;
    out_reqs_nxt    = out_reqs_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          req_mask_nxt    = '0;
          bottle_mask_nxt = '0;
          drink_nxt       = 1'b0;
          not_ready_nxt   = 1'b0;
          cnt_nxt         = '0;
          state_nxt       = ST_EMIT;
          unique case (mode_t'(in_if.mode))
            MODE_TICK: state_nxt = ST_RULE;
            MODE_BOTTLE: begin
              if (msg_ok) begin
                bottle_nxt[msg_idx] = 1'b1;
                dirty_nxt[msg_idx]  = in_if.arrives_dirty;
              end
            end
            MODE_REQUEST: begin
              if (msg_ok) req_nxt[msg_idx] = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // phase rule, one slot per cycle
      ST_RULE: begin
        bottle_nxt[cnt_r]   = rule_res.flags.bottle;
        req_nxt[cnt_r]      = rule_res.flags.request;
        need_nxt[cnt_r]     = rule_res.flags.need;
        dirty_nxt[cnt_r]    = rule_res.flags.dirty;
        req_mask_nxt[cnt_r] = rule_res.send_req;
        not_ready_nxt       = not_ready_r | rule_res.not_ready;
        if (slot_end) begin
          cnt_nxt   = '0;
          state_nxt = ST_GIVE;
          case (phase_r)
            PH_THIRSTY:
              phase_nxt = (not_ready_r | rule_res.not_ready) ? PH_THIRSTY : PH_DRINKING;
            PH_DRINKING: begin
              phase_nxt = PH_TRANQUIL;
              drink_nxt = 1'b1;
            end
            default: phase_nxt = PH_THIRSTY;
          endcase
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      // bottle-giving rule under the new phase
      ST_GIVE: begin
        bottle_nxt[cnt_r]      = rule_res.flags.bottle;
        req_nxt[cnt_r]         = rule_res.flags.request;
        need_nxt[cnt_r]        = rule_res.flags.need;
        dirty_nxt[cnt_r]       = rule_res.flags.dirty;
        bottle_mask_nxt[cnt_r] = rule_res.give_bottle;
        if (slot_end) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      // one result per cycle into the output register, unless the receiver stalls
      ST_EMIT: begin
        if (load_out) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = pick.kind;
          out_target_nxt  = pick.target;
          out_phase_nxt   = phase_r;
          out_bottles_nxt = MASK_W'(bottle_r);
          out_reqs_nxt    = MASK_W'(req_r);
          out_last_nxt    = pick.last;
          req_mask_nxt    = req_left;
          bottle_mask_nxt = bottle_left;
          drink_nxt       = drink_left;
          if (pick.last) state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // configuration writes
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_NEIGHBOR_PRESENT: present_nxt = cfg_if.data;
        CFG_START_WITH_BOTTLE: begin
          bottle_nxt = cfg_if.data[ACTIVE-1:0];
          req_nxt    = ~cfg_if.data[ACTIVE-1:0];
          need_nxt   = '0;
          dirty_nxt  = '1;
        end
        default: ;
      endcase
    end
  end

  // control and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= PH_TRANQUIL;
      cnt_r         <= '0;
      present_r     <= '1;
      bottle_r      <= '0;
      req_r         <= '1;
      need_r        <= '0;
      dirty_r       <= '1;
      req_mask_r    <= '0;
      bottle_mask_r <= '0;
      drink_r       <= 1'b0;
      not_ready_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      cnt_r         <= cnt_nxt;
      present_r     <= present_nxt;
      bottle_r      <= bottle_nxt;
      req_r         <= req_nxt;
      need_r        <= need_nxt;
      dirty_r       <= dirty_nxt;
      req_mask_r    <= req_mask_nxt;
      bottle_mask_r <= bottle_mask_nxt;
      drink_r       <= drink_nxt;
      not_ready_r   <= not_ready_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_kind_r    <= out_kind_nxt;
    out_target_r  <= out_target_nxt;
    out_phase_r   <= out_phase_nxt;
    out_bottles_r <= out_bottles_nxt;
    out_reqs_r    <= out_reqs_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.kind          = out_kind_r;
  assign out_if.target_slot   = out_target_r;
  assign out_if.phase_now     = out_phase_r;
  assign out_if.bottles_held  = out_bottles_r;
  assign out_if.requests_held = out_reqs_r;
  assign out_if.last          = out_last_r;

endmodule

`default_nettype wire

// ===== sv/dpn_checker.sv =====
// Port-level checker for the drinking philosopher node, bound to the top level.
// Depends on dpn_pkg and drinking_philosopher_node.
`timescale 1ns / 1ps
`default_nettype none

module dpn_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                out_kind,
  input logic [dpn_pkg::SLOT_W-1:0] out_target_slot,
  input logic [1:0]                out_phase_now,
  input logic                      out_last
);
  import dpn_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_target_slot) && $stable(out_last))
    else $error("result changed while stalled");

  // the node is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a none result is always alone
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NONE |-> out_last)
    else $error("none result not flagged last");

  // drinking always ends in tranquil
  a_drink_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DRINK |-> out_phase_now == PH_TRANQUIL)
    else $error("drink report with wrong phase");

endmodule

bind drinking_philosopher_node dpn_checker u_dpn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_kind        (out_if.kind),
  .out_target_slot (out_if.target_slot),
  .out_phase_now   (out_if.phase_now),
  .out_last        (out_if.last)
);

`default_nettype wire
